[rtl/amg_pkg.sv]
// azimuthal max gap: shared constants, state type and control structs
// no dependencies
`timescale 1ns / 1ps

package amg_pkg;

  localparam int AZ_W             = 16;
  localparam int GAP_W            = 17;
  localparam int MAX_AZIMUTHS_DEF = 64;

  localparam logic [AZ_W-1:0]  AZ_MAX      = 16'd35999;
  localparam logic [GAP_W-1:0] FULL_CIRCLE = 17'd36000;

  typedef enum logic {
    ST_COLLECT,
    ST_SCAN
  } amg_state_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic run;
    logic clear;
  } scan_ctl_t;

endpackage

[rtl/amg_cell.sv]
// azimuthal max gap: one cell of the sorted insertion chain
// depends on amg_pkg
`timescale 1ns / 1ps

module amg_cell
  import amg_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cell_ctl_t       ctl,
  input  logic [AZ_W-1:0] az,
  input  logic [AZ_W-1:0] prev_val,
  input  logic            prev_valid,
  input  logic            prev_ins,
  input  logic [AZ_W-1:0] next_val,
  input  logic            next_valid,
  output logic [AZ_W-1:0] val,
  output logic            valid,
  output logic            ins
);

  logic [AZ_W-1:0] val_r, val_nxt;
  logic            valid_r, valid_nxt;

  // insertion point or beyond
  assign ins = !valid_r || (val_r > az);

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctl.insert) begin
      if (prev_ins) begin
        val_nxt   = prev_val;
        valid_nxt = prev_valid;
      end else if (ins) begin
        val_nxt   = az;
        valid_nxt = 1'b1;
      end
    end else if (ctl.shift) begin
      val_nxt   = next_val;
      valid_nxt = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign valid = valid_r;

endmodule

[rtl/amg_gap_scan.sv]
// azimuthal max gap: serial gap scan over the values drained from the chain head
// depends on amg_pkg
`timescale 1ns / 1ps

module amg_gap_scan
  import amg_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  scan_ctl_t       ctl,
  input  logic [AZ_W-1:0] head_val,
  input  logic            head_valid,
  output logic [AZ_W-1:0] gap
);

  logic [AZ_W-1:0]  first_r, first_nxt;
  logic [AZ_W-1:0]  prev_r, prev_nxt;
  logic [AZ_W-1:0]  best_r, best_nxt;
  logic             have_r, have_nxt;
  logic [AZ_W-1:0]  diff;
  logic [GAP_W-1:0] wrap;

  assign diff = head_val - prev_r;

  always_comb begin
    first_nxt = first_r;
    prev_nxt  = prev_r;
    best_nxt  = best_r;
    have_nxt  = have_r;
    if (ctl.clear) begin
      best_nxt = '0;
      have_nxt = 1'b0;
    end else if (ctl.run && head_valid) begin
      prev_nxt = head_val;
      have_nxt = 1'b1;
      if (!have_r) begin
        first_nxt = head_val;
      end else if (diff > best_r) begin
        best_nxt = diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
      have_r <= 1'b0;
    end else begin
      best_r <= best_nxt;
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    prev_r  <= prev_nxt;
  end

  // wrap-around gap
  assign wrap = FULL_CIRCLE - {1'b0, prev_r} + {1'b0, first_r};
  assign gap  = (wrap > {1'b0, best_r}) ? wrap[AZ_W-1:0] : best_r;

endmodule

[rtl/azimuthal_max_gap.sv]
// azimuthal max gap: top level, insertion chain plus gap scan and output register
// depends on amg_pkg, amg_cell, amg_gap_scan
`timescale 1ns / 1ps
//
// Usage:
// in_*  : one azimuth per item in in_tdata (hundredths of a degree), in_tlast on
//         the final azimuth of a set. values above 35999 are saturated.
// out_* : one result per set, max_gap in out_tdata, overflow flag in out_tuser.
// Collection takes one item per cycle: each item is inserted in sorted order into
// a chain of MAX_AZIMUTHS cells. Items beyond the chain's capacity are dropped
// and flagged.
// After the item with in_tlast, in_tready goes low while the chain drains one
// entry per cycle into the gap scan: the result is registered once the chain
// is empty again and the output register is free.
// A pending result waits in the output register; the next set is collected
// while it waits, and its scan holds at its end until the register frees.
// Synchronous reset (rst_n low) empties the chain, clears flags except out_tuser.
//

module azimuthal_max_gap
  import amg_pkg::*;
#(
  parameter int MAX_AZIMUTHS = MAX_AZIMUTHS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] azimuth
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] max_gap
  output logic        out_tuser   // [0] overflow
);

  amg_state_t state_r, state_nxt;

  logic [AZ_W-1:0] az_sat;
  logic            in_acc;
  logic            full;
  logic            out_free;
  logic            emit;
  cell_ctl_t       cell_ctl;
  scan_ctl_t       scan_ctl;
  logic [AZ_W-1:0] gap;

  logic [AZ_W-1:0]         val_w   [MAX_AZIMUTHS];
  logic [MAX_AZIMUTHS-1:0] valid_w;
  logic [MAX_AZIMUTHS-1:0] ins_w;

  logic            drop_r, drop_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [AZ_W-1:0] out_gap_r, out_gap_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  assign az_sat   = (in_tdata > AZ_MAX) ? AZ_MAX : in_tdata;
  assign in_acc   = in_tvalid && in_tready;
  assign full     = valid_w[MAX_AZIMUTHS-1];
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: begin
        if (in_acc && in_tlast) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!valid_w[0] && out_free) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    emit           = 1'b0;
    cell_ctl       = '0;
    scan_ctl       = '0;
    case (state_r)
      ST_COLLECT: begin
        in_tready       = 1'b1;
        cell_ctl.insert = in_acc && !full;
      end
      ST_SCAN: begin
        cell_ctl.shift = 1'b1;
        scan_ctl.run   = 1'b1;
        emit           = !valid_w[0] && out_free;
        scan_ctl.clear = emit;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < MAX_AZIMUTHS; i++) begin : g_cell
    logic [AZ_W-1:0] p_val, n_val;
    logic            p_valid, p_ins, n_valid;
    if (i == 0) begin : g_head
      assign p_val   = '0;
      assign p_valid = 1'b0;
      assign p_ins   = 1'b0;
    end else begin : g_body
      assign p_val   = val_w[i-1];
      assign p_valid = valid_w[i-1];
      assign p_ins   = ins_w[i-1];
    end
    if (i == MAX_AZIMUTHS - 1) begin : g_tail
      assign n_val   = '0;
      assign n_valid = 1'b0;
    end else begin : g_mid
      assign n_val   = val_w[i+1];
      assign n_valid = valid_w[i+1];
    end
    amg_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .az         (az_sat),
      .prev_val   (p_val),
      .prev_valid (p_valid),
      .prev_ins   (p_ins),
      .next_val   (n_val),
      .next_valid (n_valid),
      .val        (val_w[i]),
      .valid      (valid_w[i]),
      .ins        (ins_w[i])
    );
  end

  amg_gap_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .head_val   (val_w[0]),
    .head_valid (valid_w[0]),
    .gap        (gap)
  );

  always_comb begin
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    out_gap_nxt   = out_gap_r;
    out_ovf_nxt   = out_ovf_r;
    if (in_acc && full) begin
      drop_nxt = 1'b1;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_gap_nxt   = gap;
      out_ovf_nxt   = drop_r;
      drop_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_gap_r <= out_gap_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_gap_r;
  assign out_tuser  = out_ovf_r;

  // valid cells always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, valid_w} + {{MAX_AZIMUTHS{1'b0}}, 1'b1}))
    else $error("chain valid bits not contiguous");

  a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> !in_tready)
    else $error("input accepted during scan");

  a_drop_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full && !in_tlast) |=> drop_r)
    else $error("dropped item not flagged");

  a_gap_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= FULL_CIRCLE[AZ_W-1:0]))
    else $error("gap above full circle");

  a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (emit) |=> (valid_w == '0 && in_tready))
    else $error("result emitted with chain not drained");

endmodule
